/* rtl/sync_byte_frame_checksum_parser_defines.svh */
// Assertion macros for the frame parser.
`ifndef SYNC_BYTE_FRAME_CHECKSUM_PARSER_DEFINES_SVH
`define SYNC_BYTE_FRAME_CHECKSUM_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SBFCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbfcp assertion failed");
// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SBFCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbfcp assertion failed");
`else
`define SBFCP_ASSERT_NOW(label, ante, cons)
`define SBFCP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/sbfcp_pkg.sv */
// Shared types and constants of the frame parser.
`default_nettype none

package sbfcp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned GapW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 16;

  // Register indexes of the configuration port
  localparam logic [CfgAddrW-1:0] CfgGapTimeout = 1'd0;
  localparam logic [CfgAddrW-1:0] CfgStartCode  = 1'd1;

  localparam logic [GapW-1:0]  GapTimeoutReset = 16'd2000;
  localparam logic [ByteW-1:0] StartCodeReset  = 8'd1;

  // Result status codes
  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusChkErr  = 2'd1;
  localparam logic [StatusW-1:0] StatusTimeout = 2'd2;

  // Parser phases
  localparam logic [PhaseW-1:0] PhHunt   = 3'd0;
  localparam logic [PhaseW-1:0] PhSteer  = 3'd1;
  localparam logic [PhaseW-1:0] PhThrot  = 3'd2;
  localparam logic [PhaseW-1:0] PhButton = 3'd3;
  localparam logic [PhaseW-1:0] PhCheck  = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0]   buttons;
    logic [ByteW-1:0]   throttle;
    logic [ByteW-1:0]   steer;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

`default_nettype wire

/* rtl/sync_byte_frame_checksum_parser.sv */
// Start-byte frame parser with additive checksum, top level.
// Throughput: one byte or tick per cycle while s_axis_tready is high.
// Parse state updates on the input transfer; results are registered.
// Results go to an output register backed by one skid register, so input keeps
// flowing while a result waits; s_axis_tready drops only while the skid is full.
// Reset (rst_ni low, asynchronous): hunting, held values zero, registers to defaults.
`default_nettype none
`include "sync_byte_frame_checksum_parser_defines.svh"

module sync_byte_frame_checksum_parser
  import sbfcp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // Input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  input  wire logic                s_axis_tuser,   // [0] func: 0 byte, 1 tick
  // Result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [23:0]              m_axis_tdata,   // [7:0] steering_angle,
                                                   // [15:8] throttle_level,
                                                   // [23:16] button_bits
  output logic [StatusW-1:0]       m_axis_tuser    // [1:0] status
);

  // Configuration registers
  logic [GapW-1:0]  gap_timeout_q;
  logic [ByteW-1:0] start_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_timeout_q <= GapTimeoutReset;
      start_code_q  <= StartCodeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgGapTimeout: gap_timeout_q <= cfg_data_i;
        CfgStartCode:  start_code_q  <= cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Parser state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [GapW-1:0]   gap_q, gap_d;
  logic [ByteW-1:0]  pend_steer_q, pend_steer_d;
  logic [ByteW-1:0]  pend_throt_q, pend_throt_d;
  logic [ByteW-1:0]  pend_btn_q, pend_btn_d;
  logic [ByteW-1:0]  held_steer_q, held_steer_d;
  logic [ByteW-1:0]  held_throt_q, held_throt_d;
  logic [ByteW-1:0]  held_btn_q, held_btn_d;

  // Output register and skid register
  result_t out_q, out_d, skid_q, skid_d;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  logic             in_xfer, out_xfer;
  logic             is_tick, collecting;
  logic [GapW-1:0]  gap_inc;
  logic [ByteW-1:0] sum;
  logic             res_valid;
  result_t          res;

  assign s_axis_tready = !skid_valid_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = out_valid_q && m_axis_tready;

  assign is_tick    = s_axis_tuser;
  assign collecting = (phase_q == PhSteer) || (phase_q == PhThrot) ||
                      (phase_q == PhButton) || (phase_q == PhCheck);
  // Saturate the silence count at all ones
  assign gap_inc    = (gap_q == {GapW{1'b1}}) ? gap_q : gap_q + 1'b1;
  assign sum        = pend_steer_q + pend_throt_q + pend_btn_q;

  always_comb begin
    phase_d      = phase_q;
    gap_d        = gap_q;
    pend_steer_d = pend_steer_q;
    pend_throt_d = pend_throt_q;
    pend_btn_d   = pend_btn_q;
    held_steer_d = held_steer_q;
    held_throt_d = held_throt_q;
    held_btn_d   = held_btn_q;
    res_valid    = 1'b0;
    res.status   = StatusOk;

    if (in_xfer) begin
      if (is_tick) begin
        // Ticks only count while a frame is open
        if (collecting) begin
          gap_d = gap_inc;
          if (gap_inc >= gap_timeout_q) begin
            phase_d    = PhHunt;
            gap_d      = '0;
            res_valid  = 1'b1;
            res.status = StatusTimeout;
          end
        end
      end else begin
        gap_d = '0;
        unique case (phase_q)
          PhSteer: begin
            pend_steer_d = s_axis_tdata;
            phase_d      = PhThrot;
          end
          PhThrot: begin
            pend_throt_d = s_axis_tdata;
            phase_d      = PhButton;
          end
          PhButton: begin
            pend_btn_d = s_axis_tdata;
            phase_d    = PhCheck;
          end
          PhCheck: begin
            phase_d   = PhHunt;
            res_valid = 1'b1;
            if (s_axis_tdata == sum) begin
              held_steer_d = pend_steer_q;
              held_throt_d = pend_throt_q;
              held_btn_d   = pend_btn_q;
              res.status   = StatusOk;
            end else begin
              res.status = StatusChkErr;
            end
          end
          // Hunting, and unused codes act as hunting
          default: begin
            phase_d = (s_axis_tdata == start_code_q) ? PhSteer : PhHunt;
          end
        endcase
      end
    end

    // Results carry the held values after this item's update
    res.steer    = held_steer_d;
    res.throttle = held_throt_d;
    res.buttons  = held_btn_d;
  end

  // Two-entry result queue: output register in front, skid behind it
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_xfer) begin
      if (skid_valid_q) begin
        // Advance the skid entry; input is stalled so no new result now
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = res_valid;
      end
    end else if (res_valid) begin
      // Hold the stalled output, park the new result
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHunt;
      gap_q        <= '0;
      pend_steer_q <= '0;
      pend_throt_q <= '0;
      pend_btn_q   <= '0;
      held_steer_q <= '0;
      held_throt_q <= '0;
      held_btn_q   <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      gap_q        <= gap_d;
      pend_steer_q <= pend_steer_d;
      pend_throt_q <= pend_throt_d;
      pend_btn_q   <= pend_btn_d;
      held_steer_q <= held_steer_d;
      held_throt_q <= held_throt_d;
      held_btn_q   <= held_btn_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.buttons, out_q.throttle, out_q.steer};
  assign m_axis_tuser  = out_q.status;

  // Skid entry never exists without the output entry in front of it
  `SBFCP_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
  // Silence count is only nonzero inside a frame
  `SBFCP_ASSERT_NOW(a_gap_in_frame, gap_q != '0, collecting)
  // Ticks while hunting leave the phase alone
  `SBFCP_ASSERT_NEXT(a_tick_hunt, in_xfer && is_tick && (phase_q == PhHunt),
                     phase_q == PhHunt)
  // A good check byte loads the held values from the pending bytes
  `SBFCP_ASSERT_NEXT(a_ok_loads_held,
                     in_xfer && !is_tick && (phase_q == PhCheck) && (s_axis_tdata == sum),
                     (held_steer_q == $past(pend_steer_q)) &&
                     (held_throt_q == $past(pend_throt_q)) &&
                     (held_btn_q == $past(pend_btn_q)))

endmodule

`default_nettype wire
